// ----- rtl/tleb_pkg.sv -----
// ---------------------------------------------------------------------------
// tleb_pkg
// Types and constants shared by the longest-edge bisection pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package tleb_pkg;

  localparam int unsigned FIELD_W      = 16;
  localparam int unsigned SUM_Z_W      = 18;
  localparam int unsigned ZABS_W       = 17;
  localparam int unsigned RECIP3_W     = 18;
  localparam int unsigned RECIP3_SHIFT = 19;
  // ceil(2^19 / 3): exact floor(s / 3) for s below 2^18
  localparam logic [RECIP3_W-1:0] RECIP3 = 18'd174763;

  typedef enum logic [1:0] {
    EDGE_AB = 2'd0,
    EDGE_BC = 2'd1,
    EDGE_CA = 2'd2
  } edge_e;

  typedef struct packed {
    logic        [FIELD_W-1:0] vertex_a_x;
    logic        [FIELD_W-1:0] vertex_a_y;
    logic signed [FIELD_W-1:0] vertex_a_z;
    logic        [FIELD_W-1:0] vertex_b_x;
    logic        [FIELD_W-1:0] vertex_b_y;
    logic signed [FIELD_W-1:0] vertex_b_z;
    logic        [FIELD_W-1:0] vertex_c_x;
    logic        [FIELD_W-1:0] vertex_c_y;
    logic signed [FIELD_W-1:0] vertex_c_z;
  } tleb_in_t;

  typedef struct packed {
    logic        [1:0]         longest_edge;
    logic        [FIELD_W-1:0] mid_x;
    logic        [FIELD_W-1:0] mid_y;
    logic        [FIELD_W-1:0] center_x;
    logic        [FIELD_W-1:0] center_y;
    logic signed [FIELD_W-1:0] height_mean;
  } tleb_out_t;

  // tie-break orderings: point p above point q by y, then x
  typedef struct packed {
    logic b_over_c;
    logic a_over_c;
    logic b_over_a;
  } tleb_tie_t;

endpackage

`default_nettype wire

// ----- rtl/triangle_longest_edge_bisect.sv -----
// ---------------------------------------------------------------------------
// triangle_longest_edge_bisect
// Longest-edge bisection step: picks a triangle's longest edge and gives its
// midpoint, the centroid and the mean height.
//
// Usage:
//   in channel  : in_valid_i / in_ready_o, one triangle per item (tleb_in_t).
//   out channel : out_valid_o / out_ready_i, one result per item (tleb_out_t).
//   Four register stages: deltas and sums, then squares and reciprocal
//   products, then lengths and quotients, then the edge decision into the
//   output register. An accepted item passes through them in that order.
//   Throughput is one item per cycle without stalls; items are independent.
//   Reset clears the stage valid bits only; the pipeline comes up empty.
//   When out_ready_i is low, each stage holds its item and the stages behind
//   it keep filling bubbles until the pipe is full; then in_ready_o drops.
//   No item is lost or repeated across a stall.
//   Coordinate bits above COORD_BITS are ignored.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_longest_edge_bisect import tleb_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire tleb_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output tleb_out_t      out_data_o
);

  logic                        s1_valid, s1_ready;
  logic [2:0][COORD_BITS-1:0]  s1_dx, s1_dy, s1_mid_x, s1_mid_y;
  logic      [COORD_BITS+1:0]  s1_sum_x, s1_sum_y;
  logic signed [SUM_Z_W-1:0]   s1_sum_z;
  tleb_tie_t                   s1_tie;

  logic                        s3_valid, s3_ready;
  logic [2:0][2*COORD_BITS:0]  s3_len;
  logic [2:0][COORD_BITS-1:0]  s3_mid_x, s3_mid_y;
  logic      [COORD_BITS-1:0]  s3_cx, s3_cy;
  logic      [FIELD_W-1:0]     s3_hm;
  tleb_tie_t                   s3_tie;

  tleb_geom #(.CoordBits(COORD_BITS)) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .dx_o        (s1_dx),
    .dy_o        (s1_dy),
    .mid_x_o     (s1_mid_x),
    .mid_y_o     (s1_mid_y),
    .sum_x_o     (s1_sum_x),
    .sum_y_o     (s1_sum_y),
    .sum_z_o     (s1_sum_z),
    .tie_o       (s1_tie)
  );

  tleb_arith #(.CoordBits(COORD_BITS)) u_arith (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s1_valid),
    .in_ready_o    (s1_ready),
    .dx_i          (s1_dx),
    .dy_i          (s1_dy),
    .mid_x_i       (s1_mid_x),
    .mid_y_i       (s1_mid_y),
    .sum_x_i       (s1_sum_x),
    .sum_y_i       (s1_sum_y),
    .sum_z_i       (s1_sum_z),
    .tie_i         (s1_tie),
    .out_valid_o   (s3_valid),
    .out_ready_i   (s3_ready),
    .len_o         (s3_len),
    .mid_x_o       (s3_mid_x),
    .mid_y_o       (s3_mid_y),
    .center_x_o    (s3_cx),
    .center_y_o    (s3_cy),
    .height_mean_o (s3_hm),
    .tie_o         (s3_tie)
  );

  tleb_pick #(.CoordBits(COORD_BITS)) u_pick (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s3_valid),
    .in_ready_o    (s3_ready),
    .len_i         (s3_len),
    .mid_x_i       (s3_mid_x),
    .mid_y_i       (s3_mid_y),
    .center_x_i    (s3_cx),
    .center_y_i    (s3_cy),
    .height_mean_i (s3_hm),
    .tie_i         (s3_tie),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/tleb_geom.sv -----
// ---------------------------------------------------------------------------
// tleb_geom
// Stage 1: edge deltas, edge midpoints, coordinate sums and tie orderings.
// ---------------------------------------------------------------------------
`default_nettype none

module tleb_geom import tleb_pkg::*; #(
  parameter int unsigned CoordBits = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire tleb_in_t                          in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic        [2:0][CoordBits-1:0]       dx_o,
  output logic        [2:0][CoordBits-1:0]       dy_o,
  output logic        [2:0][CoordBits-1:0]       mid_x_o,
  output logic        [2:0][CoordBits-1:0]       mid_y_o,
  output logic             [CoordBits+1:0]       sum_x_o,
  output logic             [CoordBits+1:0]       sum_y_o,
  output logic signed      [SUM_Z_W-1:0]         sum_z_o,
  output tleb_tie_t                              tie_o
);

  logic [CoordBits-1:0] ax, ay, bx, by, cx, cy;
  logic load;

  logic                      valid_q;
  logic [2:0][CoordBits-1:0] dx_d, dy_d, mid_x_d, mid_y_d;
  logic [2:0][CoordBits-1:0] dx_q, dy_q, mid_x_q, mid_y_q;
  logic [CoordBits+1:0]      sum_x_d, sum_y_d, sum_x_q, sum_y_q;
  logic signed [SUM_Z_W-1:0] sum_z_d, sum_z_q;
  tleb_tie_t                 tie_d, tie_q;

  function automatic logic [CoordBits-1:0] absdiff(input logic [CoordBits-1:0] p,
                                                   input logic [CoordBits-1:0] q);
    absdiff = (p > q) ? (p - q) : (q - p);
  endfunction

  function automatic logic [CoordBits-1:0] half_sum(input logic [CoordBits-1:0] p,
                                                    input logic [CoordBits-1:0] q);
    logic [CoordBits:0] s;
    s = {1'b0, p} + {1'b0, q};
    half_sum = s[CoordBits:1];
  endfunction

  function automatic logic above(input logic [CoordBits-1:0] px,
                                 input logic [CoordBits-1:0] py,
                                 input logic [CoordBits-1:0] qx,
                                 input logic [CoordBits-1:0] qy);
    above = (py != qy) ? (py > qy) : (px > qx);
  endfunction

  always_comb begin
    ax = in_data_i.vertex_a_x[CoordBits-1:0];
    ay = in_data_i.vertex_a_y[CoordBits-1:0];
    bx = in_data_i.vertex_b_x[CoordBits-1:0];
    by = in_data_i.vertex_b_y[CoordBits-1:0];
    cx = in_data_i.vertex_c_x[CoordBits-1:0];
    cy = in_data_i.vertex_c_y[CoordBits-1:0];

    dx_d[EDGE_AB] = absdiff(ax, bx);
    dy_d[EDGE_AB] = absdiff(ay, by);
    dx_d[EDGE_BC] = absdiff(bx, cx);
    dy_d[EDGE_BC] = absdiff(by, cy);
    dx_d[EDGE_CA] = absdiff(cx, ax);
    dy_d[EDGE_CA] = absdiff(cy, ay);

    mid_x_d[EDGE_AB] = half_sum(ax, bx);
    mid_y_d[EDGE_AB] = half_sum(ay, by);
    mid_x_d[EDGE_BC] = half_sum(bx, cx);
    mid_y_d[EDGE_BC] = half_sum(by, cy);
    mid_x_d[EDGE_CA] = half_sum(ax, cx);
    mid_y_d[EDGE_CA] = half_sum(ay, cy);

    sum_x_d = (CoordBits+2)'(ax) + (CoordBits+2)'(bx) + (CoordBits+2)'(cx);
    sum_y_d = (CoordBits+2)'(ay) + (CoordBits+2)'(by) + (CoordBits+2)'(cy);
    sum_z_d = SUM_Z_W'(in_data_i.vertex_a_z) + SUM_Z_W'(in_data_i.vertex_b_z)
            + SUM_Z_W'(in_data_i.vertex_c_z);

    tie_d.b_over_c = above(bx, by, cx, cy);
    tie_d.a_over_c = above(ax, ay, cx, cy);
    tie_d.b_over_a = above(bx, by, ax, ay);
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      mid_x_q <= mid_x_d;
      mid_y_q <= mid_y_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      sum_z_q <= sum_z_d;
      tie_q   <= tie_d;
    end
  end

  assign out_valid_o = valid_q;
  assign dx_o        = dx_q;
  assign dy_o        = dy_q;
  assign mid_x_o     = mid_x_q;
  assign mid_y_o     = mid_y_q;
  assign sum_x_o     = sum_x_q;
  assign sum_y_o     = sum_y_q;
  assign sum_z_o     = sum_z_q;
  assign tie_o       = tie_q;

endmodule

`default_nettype wire

// ----- rtl/tleb_arith.sv -----
// ---------------------------------------------------------------------------
// tleb_arith
// Stages 2 and 3: squared edge lengths and divide-by-three by reciprocal.
// ---------------------------------------------------------------------------
`default_nettype none

module tleb_arith import tleb_pkg::*; #(
  parameter int unsigned CoordBits = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic        [2:0][CoordBits-1:0]  dx_i,
  input  wire logic        [2:0][CoordBits-1:0]  dy_i,
  input  wire logic        [2:0][CoordBits-1:0]  mid_x_i,
  input  wire logic        [2:0][CoordBits-1:0]  mid_y_i,
  input  wire logic             [CoordBits+1:0]  sum_x_i,
  input  wire logic             [CoordBits+1:0]  sum_y_i,
  input  wire logic signed      [SUM_Z_W-1:0]    sum_z_i,
  input  wire tleb_tie_t                         tie_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic        [2:0][2*CoordBits:0]       len_o,
  output logic        [2:0][CoordBits-1:0]       mid_x_o,
  output logic        [2:0][CoordBits-1:0]       mid_y_o,
  output logic             [CoordBits-1:0]       center_x_o,
  output logic             [CoordBits-1:0]       center_y_o,
  output logic             [FIELD_W-1:0]         height_mean_o,
  output tleb_tie_t                              tie_o
);

  localparam int unsigned SqW   = 2 * CoordBits;
  localparam int unsigned ProdW = CoordBits + 2 + RECIP3_W;
  localparam int unsigned ZProdW = ZABS_W + RECIP3_W;

  // stage 2
  logic                      v2_q, r2, load2;
  logic [2:0][SqW-1:0]       sq_x_d, sq_y_d, sq_x_q, sq_y_q;
  logic [ProdW-1:0]          prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic [SUM_Z_W-1:0]        zneg_full;
  logic [ZABS_W-1:0]         zabs_d, zabs_q;
  logic                      zneg_q;
  logic [2:0][CoordBits-1:0] mid_x2_q, mid_y2_q;
  tleb_tie_t                 tie2_q;

  // stage 3
  logic                      v3_q, r3, load3;
  logic [2:0][SqW:0]         len_d, len_q;
  logic [ZProdW-1:0]         zprod;
  logic [FIELD_W-1:0]        zquot, hm_d, hm_q;
  logic [CoordBits-1:0]      cx_q, cy_q;
  logic [2:0][CoordBits-1:0] mid_x3_q, mid_y3_q;
  tleb_tie_t                 tie3_q;

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      sq_x_d[e] = SqW'(dx_i[e]) * SqW'(dx_i[e]);
      sq_y_d[e] = SqW'(dy_i[e]) * SqW'(dy_i[e]);
      len_d[e]  = (SqW+1)'(sq_x_q[e]) + (SqW+1)'(sq_y_q[e]);
    end
    prod_x_d  = ProdW'(sum_x_i) * ProdW'(RECIP3);
    prod_y_d  = ProdW'(sum_y_i) * ProdW'(RECIP3);
    zneg_full = -sum_z_i;
    zabs_d    = sum_z_i[SUM_Z_W-1] ? zneg_full[ZABS_W-1:0] : sum_z_i[ZABS_W-1:0];
    zprod     = ZProdW'(zabs_q) * ZProdW'(RECIP3);
    zquot     = zprod[RECIP3_SHIFT +: FIELD_W];
    hm_d      = zneg_q ? (~zquot + 1'b1) : zquot;
  end

  assign r3         = !v3_q || out_ready_i;
  assign r2         = !v2_q || r3;
  assign load2      = in_valid_i && r2;
  assign load3      = v2_q && r3;
  assign in_ready_o = r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r2) begin
        v2_q <= in_valid_i;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      sq_x_q   <= sq_x_d;
      sq_y_q   <= sq_y_d;
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      zabs_q   <= zabs_d;
      zneg_q   <= sum_z_i[SUM_Z_W-1];
      mid_x2_q <= mid_x_i;
      mid_y2_q <= mid_y_i;
      tie2_q   <= tie_i;
    end
    if (load3) begin
      len_q    <= len_d;
      cx_q     <= prod_x_q[RECIP3_SHIFT +: CoordBits];
      cy_q     <= prod_y_q[RECIP3_SHIFT +: CoordBits];
      hm_q     <= hm_d;
      mid_x3_q <= mid_x2_q;
      mid_y3_q <= mid_y2_q;
      tie3_q   <= tie2_q;
    end
  end

  assign out_valid_o   = v3_q;
  assign len_o         = len_q;
  assign mid_x_o       = mid_x3_q;
  assign mid_y_o       = mid_y3_q;
  assign center_x_o    = cx_q;
  assign center_y_o    = cy_q;
  assign height_mean_o = hm_q;
  assign tie_o         = tie3_q;

endmodule

`default_nettype wire

// ----- rtl/tleb_pick.sv -----
// ---------------------------------------------------------------------------
// tleb_pick
// Stage 4: longest-edge decision with tie-break, midpoint select, output reg.
// ---------------------------------------------------------------------------
`default_nettype none

module tleb_pick import tleb_pkg::*; #(
  parameter int unsigned CoordBits = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic        [2:0][2*CoordBits:0]  len_i,
  input  wire logic        [2:0][CoordBits-1:0]  mid_x_i,
  input  wire logic        [2:0][CoordBits-1:0]  mid_y_i,
  input  wire logic             [CoordBits-1:0]  center_x_i,
  input  wire logic             [CoordBits-1:0]  center_y_i,
  input  wire logic             [FIELD_W-1:0]    height_mean_i,
  input  wire tleb_tie_t                         tie_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output tleb_out_t                              out_data_o
);

  logic [2*CoordBits:0] ab, bc, ca;
  edge_e                sel;
  logic                 valid_q, load;
  tleb_out_t            data_d, data_q;

  always_comb begin
    ab = len_i[EDGE_AB];
    bc = len_i[EDGE_BC];
    ca = len_i[EDGE_CA];
    priority if (ab > bc) begin
      priority if (ab > ca)       sel = EDGE_AB;
      else if (ab == ca)          sel = tie_i.b_over_c ? EDGE_CA : EDGE_AB;
      else                        sel = EDGE_CA;
    end else if (ab == bc) begin
      priority if (ab >= ca)      sel = tie_i.a_over_c ? EDGE_BC : EDGE_AB;
      else                        sel = EDGE_CA;
    end else begin
      priority if (bc > ca)       sel = EDGE_BC;
      else if (bc == ca)          sel = tie_i.b_over_a ? EDGE_CA : EDGE_BC;
      else                        sel = EDGE_CA;
    end

    data_d.longest_edge = sel;
    data_d.mid_x        = FIELD_W'(mid_x_i[sel]);
    data_d.mid_y        = FIELD_W'(mid_y_i[sel]);
    data_d.center_x     = FIELD_W'(center_x_i);
    data_d.center_y     = FIELD_W'(center_y_i);
    data_d.height_mean  = height_mean_i;
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for triangle_longest_edge_bisect. Directed triangles
// cover extreme coordinates and heights, each tie-break rule, and degenerate
// shapes. About 1500 random triangles follow: unconstrained ones, clustered
// ones, and isosceles ones that force ties. Handshake pressure varies by
// phase. Every result is checked against a local model of the bisection step.
// ---------------------------------------------------------------------------

module tb;
  import tleb_pkg::*;

  localparam int unsigned COORD_BITS  = 16;
  localparam logic [15:0] COORD_MASK  = 16'((32'd1 << COORD_BITS) - 1);
  localparam int          STALL_LIMIT = 2000;
  localparam int          MAX_REPORTS = 10;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  tleb_in_t  in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  tleb_out_t out_data_o;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_req  = 0;
  int stuck_cycles = 0;

  triangle_longest_edge_bisect #(
    .COORD_BITS (COORD_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  class edge_scoreboard;
    tleb_out_t pending_bisections[$];
    int        errors;
    int        checked;
    int        tie_hits;
    int        edge_hits[3];

    function automatic logic [33:0] dist2(logic [15:0] px, logic [15:0] py,
                                          logic [15:0] qx, logic [15:0] qy);
      logic [15:0] dx;
      logic [15:0] dy;
      dx = (px > qx) ? px - qx : qx - px;
      dy = (py > qy) ? py - qy : qy - py;
      return 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
    endfunction

    // p above q: by y, then by x
    function automatic bit above(logic [15:0] px, logic [15:0] py,
                                 logic [15:0] qx, logic [15:0] qy);
      if (py != qy) return py > qy;
      return px > qx;
    endfunction

    function automatic tleb_out_t bisect_triangle(input tleb_in_t t, output bit tied);
      logic [15:0] ax, ay, bx, by, cx, cy, px, py, qx, qy;
      logic [33:0] ab, bc, ca;
      logic [17:0] sum_x, sum_y;
      int          z_sum;
      edge_e       e;
      tleb_out_t   r;
      ax = t.vertex_a_x & COORD_MASK;
      ay = t.vertex_a_y & COORD_MASK;
      bx = t.vertex_b_x & COORD_MASK;
      by = t.vertex_b_y & COORD_MASK;
      cx = t.vertex_c_x & COORD_MASK;
      cy = t.vertex_c_y & COORD_MASK;
      ab = dist2(ax, ay, bx, by);
      bc = dist2(bx, by, cx, cy);
      ca = dist2(cx, cy, ax, ay);
      tied = 1'b0;
      if (ab > bc) begin
        if (ab > ca) begin
          e = EDGE_AB;
        end else if (ab == ca) begin
          tied = 1'b1;
          e = above(bx, by, cx, cy) ? EDGE_CA : EDGE_AB;
        end else begin
          e = EDGE_CA;
        end
      end else if (ab == bc) begin
        if (ab >= ca) begin
          tied = 1'b1;
          e = above(ax, ay, cx, cy) ? EDGE_BC : EDGE_AB;
        end else begin
          e = EDGE_CA;
        end
      end else begin
        if (bc > ca) begin
          e = EDGE_BC;
        end else if (bc == ca) begin
          tied = 1'b1;
          e = above(bx, by, ax, ay) ? EDGE_CA : EDGE_BC;
        end else begin
          e = EDGE_CA;
        end
      end
      case (e)
        EDGE_AB: begin
          px = ax; py = ay; qx = bx; qy = by;
        end
        EDGE_BC: begin
          px = cx; py = cy; qx = bx; qy = by;
        end
        default: begin
          px = ax; py = ay; qx = cx; qy = cy;
        end
      endcase
      sum_x = 18'(ax) + 18'(bx) + 18'(cx);
      sum_y = 18'(ay) + 18'(by) + 18'(cy);
      z_sum = int'($signed(t.vertex_a_z)) + int'($signed(t.vertex_b_z))
            + int'($signed(t.vertex_c_z));
      r.longest_edge = e;
      r.mid_x        = 16'((17'(px) + 17'(qx)) >> 1);
      r.mid_y        = 16'((17'(py) + 17'(qy)) >> 1);
      r.center_x     = 16'(sum_x / 18'd3);
      r.center_y     = 16'(sum_y / 18'd3);
      r.height_mean  = 16'(z_sum / 3);
      return r;
    endfunction

    function void note_input(tleb_in_t t);
      tleb_out_t r;
      bit        tied;
      r = bisect_triangle(t, tied);
      if (tied) tie_hits++;
      pending_bisections.push_back(r);
    endfunction

    function void check_result(tleb_out_t got);
      tleb_out_t exp_r;
      string     bad;
      bad = "";
      if (pending_bisections.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("tb: result with no triangle outstanding: edge %0d mid (%0d,%0d)",
                   got.longest_edge, got.mid_x, got.mid_y);
        return;
      end
      exp_r = pending_bisections.pop_front();
      checked++;
      if (exp_r.longest_edge < 3) edge_hits[exp_r.longest_edge]++;
      if (got.longest_edge != exp_r.longest_edge) bad = {bad, " longest_edge"};
      if (got.mid_x != exp_r.mid_x)               bad = {bad, " mid_x"};
      if (got.mid_y != exp_r.mid_y)               bad = {bad, " mid_y"};
      if (got.center_x != exp_r.center_x)         bad = {bad, " center_x"};
      if (got.center_y != exp_r.center_y)         bad = {bad, " center_y"};
      if (got.height_mean != exp_r.height_mean)   bad = {bad, " height_mean"};
      if (bad != "") begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("tb: mismatch on%s: exp edge %0d mid (%0d,%0d) ctr (%0d,%0d) z %0d",
                   bad, exp_r.longest_edge, exp_r.mid_x, exp_r.mid_y, exp_r.center_x,
                   exp_r.center_y, exp_r.height_mean);
          $display("tb:   got edge %0d mid (%0d,%0d) ctr (%0d,%0d) z %0d",
                   got.longest_edge, got.mid_x, got.mid_y, got.center_x,
                   got.center_y, got.height_mean);
        end
      end
    endfunction

    function int pending();
      return pending_bisections.size();
    endfunction
  endclass

  edge_scoreboard sb = new();

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin : rx_drive
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // sample mid-cycle: values here are what the next rising edge sees
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("tb: no item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.pending());
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic offer_triangle(input tleb_in_t tri_in);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tri_in;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic send_tri(input int ax, input int ay, input int az,
                          input int bx, input int by, input int bz,
                          input int cx, input int cy, input int cz);
    tleb_in_t t;
    t = '{16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
          16'(cx), 16'(cy), 16'(cz)};
    offer_triangle(t);
  endtask

  function automatic logic [15:0] pick_height();
    if ($urandom_range(0, 9) != 0) return 16'($urandom);
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  // mix: unconstrained, tiny grid (frequent ties), local clusters, isosceles
  task automatic send_random_triangle();
    logic [15:0] vx[3];
    logic [15:0] vy[3];
    logic [15:0] px, py, dx, dy, qx, qy, rx, ry;
    int          kind, apex, sel;
    tleb_in_t    t;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      for (int i = 0; i < 3; i++) begin
        vx[i] = 16'($urandom);
        vy[i] = 16'($urandom);
      end
    end else if (kind < 6) begin
      for (int i = 0; i < 3; i++) begin
        vx[i] = 16'($urandom_range(0, 3));
        vy[i] = 16'($urandom_range(0, 3));
      end
    end else if (kind < 8) begin
      px = ($urandom_range(0, 3) == 0) ? 16'd65528 : 16'($urandom_range(0, 65528));
      py = ($urandom_range(0, 3) == 0) ? 16'd65528 : 16'($urandom_range(0, 65528));
      for (int i = 0; i < 3; i++) begin
        vx[i] = px + 16'($urandom_range(0, 7));
        vy[i] = py + 16'($urandom_range(0, 7));
      end
    end else begin
      px = 16'($urandom_range(16, 65519));
      py = 16'($urandom_range(16, 65519));
      dx = 16'($urandom_range(0, 15));
      dy = 16'($urandom_range(0, 15));
      qx = px + dx;
      qy = py + dy;
      sel = $urandom_range(0, 3);
      case (sel)
        0:       begin rx = px - dx; ry = py + dy; end
        1:       begin rx = px + dx; ry = py - dy; end
        2:       begin rx = px + dy; ry = py + dx; end
        default: begin rx = px - dy; ry = py - dx; end
      endcase
      apex = $urandom_range(0, 2);
      sel  = $urandom_range(0, 1);
      vx[apex] = px;
      vy[apex] = py;
      vx[(apex + 1 + sel) % 3] = qx;
      vy[(apex + 1 + sel) % 3] = qy;
      vx[(apex + 2 - sel) % 3] = rx;
      vy[(apex + 2 - sel) % 3] = ry;
    end
    t = '{vx[0], vy[0], pick_height(), vx[1], vy[1], pick_height(),
          vx[2], vy[2], pick_height()};
    offer_triangle(t);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    repeat (count) send_random_triangle();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of coordinates and heights
    send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_tri(65535, 65535, 32767, 65535, 65535, 32767, 65535, 65535, 32767);
    send_tri(0, 65535, -32768, 65535, 0, -32768, 65535, 65535, -32768);
    send_tri(0, 0, -4, 65535, 0, 0, 0, 1, 0);
    send_tri(0, 0, -1, 0, 1, -1, 65535, 65535, 0);
    send_tri(0, 65535, 5, 1, 0, 0, 65535, 0, 0);
    send_tri(65534, 1, -5, 3, 65533, 0, 100, 200, 0);
    // tie a-b vs c-a: by y, then by x
    send_tri(0, 0, 1, 3, 4, 2, 5, 0, 3);
    send_tri(0, 0, 1, 5, 0, 2, 3, 4, 3);
    send_tri(10, 0, 0, 11, 5, 0, 9, 5, 0);
    send_tri(10, 0, 0, 9, 5, 0, 11, 5, 0);
    // tie a-b vs b-c
    send_tri(3, 4, 0, 0, 0, 0, 5, 0, 0);
    send_tri(5, 0, 0, 0, 0, 0, 3, 4, 0);
    send_tri(11, 5, 0, 10, 0, 0, 9, 5, 0);
    send_tri(9, 5, 0, 10, 0, 0, 11, 5, 0);
    // tie b-c vs c-a
    send_tri(5, 0, 0, 3, 4, 0, 0, 0, 0);
    send_tri(3, 4, 0, 5, 0, 0, 0, 0, 0);
    send_tri(9, 5, 0, 11, 5, 0, 10, 0, 0);
    send_tri(11, 5, 0, 9, 5, 0, 10, 0, 0);
    // degenerate: collinear, two coincident points
    send_tri(0, 0, 7, 1, 1, 7, 2, 2, 7);
    send_tri(5, 5, -7, 5, 5, -7, 7, 9, -8);
    send_tri(65535, 0, 0, 0, 65535, 0, 32767, 32768, 0);

    run_random(350, 0, 0);
    run_random(350, 61, 0);
    run_random(350, 0, 61);
    run_random(350, 19, 19);

    // long receiver hold-off while items keep coming
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_req  = 300;
    repeat (60) send_random_triangle();
    // sender pause until the pipe has drained
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    run_random(90, 19, 19);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("tb: %0d triangles checked, longest a-b/b-c/c-a %0d/%0d/%0d, %0d tie-breaks",
             sb.checked, sb.edge_hits[0], sb.edge_hits[1], sb.edge_hits[2], sb.tie_hits);
    $display("tb: %0d mismatches over idle, stall, hold-off and drain phases",
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
